// File: rtl/vba_pkg.sv
package vba_pkg;

  // Volume limits and number format.
  localparam int MAX_X     = 128;
  localparam int MAX_Y     = 128;
  localparam int MAX_Z     = 128;
  localparam int FRAC_BITS = 8;

  localparam int VAL_W     = FRAC_BITS + 1;
  localparam int COORD_W   = 7;
  localparam int SIZE_W    = 8;
  localparam int CFG_IDX_W = 2;

  // Row and plane buffers.
  localparam int ROW_AW      = $clog2(MAX_X);
  localparam int PLANE_DEPTH = MAX_X * MAX_Y;
  localparam int PLANE_AW    = $clog2(PLANE_DEPTH);

  // Adder widths: two sums of four samples, then the full sum of eight.
  localparam int HALF_W = VAL_W + 2;
  localparam int SUM_W  = VAL_W + 3;

  // Result buffer in the back end.
  localparam int OUT_DEPTH = 8;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  // Item queue between front and back end.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(128);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = CFG_IDX_W'(2);

  // One classified voxel on its way from the front end to the back end.
  typedef struct packed {
    logic [VAL_W-1:0]    sample;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [COORD_W-1:0]  z;
    logic                has_mean;
    logic                has_pass;
    logic                up_ok;
    logic [PLANE_AW-1:0] here_addr;
    logic [PLANE_AW-1:0] up_addr;
    logic [PLANE_AW-1:0] wr_addr;
  } item_t;

  // Queue status seen by the front end and the back end.
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

  // One voxel's results waiting for the output port.
  typedef struct packed {
    logic [VAL_W-1:0]   mean;
    logic [VAL_W-1:0]   sample;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               has_mean;
    logic               has_pass;
  } out_ent_t;

  // Last valid index along an axis; zero acts as one, large values clamp.
  function automatic logic [COORD_W-1:0] last_index(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] e;
    if (v == '0) begin
      e = SIZE_W'(1);
    end else if (v > maxv) begin
      e = maxv;
    end else begin
      e = v;
    end
    return COORD_W'(e - SIZE_W'(1));
  endfunction

  // Linear address of (x, y) in the plane buffer.
  function automatic logic [PLANE_AW-1:0] plane_addr(input logic [COORD_W-1:0] y,
                                                     input logic [COORD_W-1:0] x);
    return PLANE_AW'(y) * PLANE_AW'(MAX_X) + PLANE_AW'(x);
  endfunction

endpackage

// File: rtl/vba_front.sv
module vba_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [vba_pkg::VAL_W-1:0]      sample_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [vba_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [vba_pkg::SIZE_W-1:0]     cfg_data_i,
  input  vba_pkg::q_stat_t               q_stat_i,
  output logic                           q_push_o,
  output vba_pkg::item_t                 q_item_o
);
  import vba_pkg::*;

  logic [SIZE_W-1:0]  sx_q, sx_d, sy_q, sy_d, sz_q, sz_d;
  logic [COORD_W-1:0] px_q, px_d, py_q, py_d, pz_q, pz_d;
  logic [COORD_W-1:0] lim_x, lim_y, lim_z;
  logic               restart;
  logic               accept;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;

  assign lim_x = last_index(sx_q, SIZE_W'(MAX_X));
  assign lim_y = last_index(sy_q, SIZE_W'(MAX_Y));
  assign lim_z = last_index(sz_q, SIZE_W'(MAX_Z));

  // Size registers; any write to one of them restarts the scan.
  always_comb begin
    sx_d    = sx_q;
    sy_d    = sy_q;
    sz_d    = sz_q;
    restart = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SIZE_X: begin
          sx_d    = cfg_data_i;
          restart = 1'b1;
        end
        REG_SIZE_Y: begin
          sy_d    = cfg_data_i;
          restart = 1'b1;
        end
        REG_SIZE_Z: begin
          sz_d    = cfg_data_i;
          restart = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Raster position: x fastest, then y, then z, wrapping at the volume end.
  always_comb begin
    px_d = px_q;
    py_d = py_q;
    pz_d = pz_q;
    if (restart) begin
      px_d = '0;
      py_d = '0;
      pz_d = '0;
    end else if (accept) begin
      if (px_q == lim_x) begin
        px_d = '0;
        if (py_q == lim_y) begin
          py_d = '0;
          pz_d = (pz_q == lim_z) ? '0 : pz_q + COORD_W'(1);
        end else begin
          py_d = py_q + COORD_W'(1);
        end
      end else begin
        px_d = px_q + COORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q <= SIZE_RESET;
      sy_q <= SIZE_RESET;
      sz_q <= SIZE_RESET;
      px_q <= '0;
      py_q <= '0;
      pz_q <= '0;
    end else begin
      sx_q <= sx_d;
      sy_q <= sy_d;
      sz_q <= sz_d;
      px_q <= px_d;
      py_q <= py_d;
      pz_q <= pz_d;
    end
  end

  // Classify the beat and work out its buffer addresses.
  always_comb begin
    q_item_o.sample    = sample_i;
    q_item_o.x         = px_q;
    q_item_o.y         = py_q;
    q_item_o.z         = pz_q;
    q_item_o.has_mean  = (px_q != '0) && (py_q != '0) && (pz_q != '0);
    q_item_o.has_pass  = (px_q == lim_x) || (py_q == lim_y) || (pz_q == lim_z);
    q_item_o.up_ok     = (py_q != '0);
    q_item_o.here_addr = plane_addr(py_q, px_q);
    q_item_o.up_addr   = plane_addr(py_q - COORD_W'(1), px_q);
    q_item_o.wr_addr   = (py_q != '0) ? plane_addr(py_q - COORD_W'(1), px_q)
                                      : plane_addr(lim_y, px_q);
  end

  assign q_push_o = accept;

endmodule

// File: rtl/vba_queue.sv
module vba_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  vba_pkg::item_t   item_i,
  input  logic             pop_i,
  output vba_pkg::item_t   item_o,
  output vba_pkg::q_stat_t stat_o
);
  import vba_pkg::*;

  item_t            ent_q [Q_DEPTH];
  logic [Q_AW-1:0]  wr_q, rd_q;
  logic [Q_CW-1:0]  cnt_q;

  assign stat_o.full      = (cnt_q == Q_CW'(Q_DEPTH));
  assign stat_o.not_empty = (cnt_q != '0);
  assign item_o           = ent_q[rd_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_q + Q_AW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_q + Q_AW'(1);
      end
      cnt_q <= cnt_q + Q_CW'(push_i) - Q_CW'(pop_i);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= item_i;
    end
  end

endmodule

// File: rtl/vba_back.sv
module vba_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  vba_pkg::q_stat_t              q_stat_i,
  input  vba_pkg::item_t                q_item_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [vba_pkg::VAL_W-1:0]     result_o,
  output logic [vba_pkg::COORD_W-1:0]   coord_x_o,
  output logic [vba_pkg::COORD_W-1:0]   coord_y_o,
  output logic [vba_pkg::COORD_W-1:0]   coord_z_o,
  output logic                          run_last_o
);
  import vba_pkg::*;

  // Buffers of earlier samples.
  logic [VAL_W-1:0] row_mem   [MAX_X];
  logic [VAL_W-1:0] plane_mem [PLANE_DEPTH];
  logic [VAL_W-1:0] row_rd_q, here_rd_q, up_rd_q;

  // Read stage.
  logic             a_v_q;
  item_t            a_q;
  logic [VAL_W-1:0] r_row, pl_here, pl_up;
  logic [HALF_W-1:0] sum_lo, sum_hi;

  // Most recent buffer write, for reads issued at the same edge.
  logic                lw_v_q;
  logic [COORD_W-1:0]  lw_x_q;
  logic [VAL_W-1:0]    lw_s_q;
  logic [PLANE_AW-1:0] lw_wr_q;
  logic [VAL_W-1:0]    lw_rrow_q;

  // The x-1 neighbors of the cube.
  logic [VAL_W-1:0] prev_s_q, prev_row_q, prev_here_q, prev_up_q;

  // Sum stage.
  logic               b_v_q;
  logic [VAL_W-1:0]   b_sample_q;
  logic [COORD_W-1:0] b_x_q, b_y_q, b_z_q;
  logic               b_has_mean_q, b_has_pass_q;
  logic [HALF_W-1:0]  b_lo_q, b_hi_q;
  logic [SUM_W-1:0]   sum_all;

  // Result buffer.
  out_ent_t           ent_q [OUT_DEPTH];
  out_ent_t           head;
  logic [OUT_AW-1:0]  owr_q, ord_q;
  logic [OUT_CW-1:0]  ocnt_q;
  logic [OUT_CW:0]    used;
  logic               phase_q;
  logic               issue, opush, opop, ofire, show_mean;

  // Issue only when every voxel in flight is sure of a place in the result buffer.
  assign used    = (OUT_CW+1)'(a_v_q) + (OUT_CW+1)'(b_v_q) + (OUT_CW+1)'(ocnt_q);
  assign issue   = q_stat_i.not_empty && (used < (OUT_CW+1)'(OUT_DEPTH));
  assign q_pop_o = issue;

  // Buffer reads at issue, buffer writes when the voxel leaves the read stage.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      row_rd_q  <= row_mem[q_item_i.x[ROW_AW-1:0]];
      here_rd_q <= plane_mem[q_item_i.here_addr];
      up_rd_q   <= plane_mem[q_item_i.up_addr];
    end
    if (a_v_q) begin
      row_mem[a_q.x[ROW_AW-1:0]] <= a_q.sample;
      plane_mem[a_q.wr_addr]     <= r_row;
    end
  end

  // Forward the write made at the edge of the read.
  always_comb begin
    r_row   = (lw_v_q && (lw_x_q == a_q.x)) ? lw_s_q : row_rd_q;
    pl_here = (lw_v_q && (lw_wr_q == a_q.here_addr)) ? lw_rrow_q : here_rd_q;
    pl_up   = (lw_v_q && (lw_wr_q == a_q.up_addr)) ? lw_rrow_q : up_rd_q;
    if (!a_q.up_ok) begin
      pl_up = '0;
    end
  end

  // Two partial sums of four samples each.
  assign sum_lo = HALF_W'(a_q.sample) + HALF_W'(prev_s_q)
                + HALF_W'(r_row) + HALF_W'(prev_row_q);
  assign sum_hi = HALF_W'(pl_here) + HALF_W'(prev_here_q)
                + HALF_W'(pl_up) + HALF_W'(prev_up_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q       <= 1'b0;
      b_v_q       <= 1'b0;
      lw_v_q      <= 1'b0;
      prev_s_q    <= '0;
      prev_row_q  <= '0;
      prev_here_q <= '0;
      prev_up_q   <= '0;
    end else begin
      a_v_q <= issue;
      b_v_q <= a_v_q;
      if (a_v_q) begin
        lw_v_q      <= 1'b1;
        prev_s_q    <= a_q.sample;
        prev_row_q  <= r_row;
        prev_here_q <= pl_here;
        prev_up_q   <= pl_up;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      a_q <= q_item_i;
    end
    if (a_v_q) begin
      lw_x_q       <= a_q.x;
      lw_s_q       <= a_q.sample;
      lw_wr_q      <= a_q.wr_addr;
      lw_rrow_q    <= r_row;
      b_sample_q   <= a_q.sample;
      b_x_q        <= a_q.x;
      b_y_q        <= a_q.y;
      b_z_q        <= a_q.z;
      b_has_mean_q <= a_q.has_mean;
      b_has_pass_q <= a_q.has_pass;
      b_lo_q       <= sum_lo;
      b_hi_q       <= sum_hi;
    end
  end

  // Mean of the cube: full sum shifted right by three.
  assign sum_all = SUM_W'(b_lo_q) + SUM_W'(b_hi_q);
  assign opush   = b_v_q && (b_has_mean_q || b_has_pass_q);

  always_ff @(posedge clk_i) begin
    if (opush) begin
      ent_q[owr_q].mean     <= sum_all[SUM_W-1:3];
      ent_q[owr_q].sample   <= b_sample_q;
      ent_q[owr_q].x        <= b_x_q;
      ent_q[owr_q].y        <= b_y_q;
      ent_q[owr_q].z        <= b_z_q;
      ent_q[owr_q].has_mean <= b_has_mean_q;
      ent_q[owr_q].has_pass <= b_has_pass_q;
    end
  end

  // Output side: the mean beat first, then the pass-through beat.
  assign head        = ent_q[ord_q];
  assign show_mean   = head.has_mean && !phase_q;
  assign out_valid_o = (ocnt_q != '0);
  assign result_o    = show_mean ? head.mean : head.sample;
  assign coord_x_o   = show_mean ? head.x - COORD_W'(1) : head.x;
  assign coord_y_o   = show_mean ? head.y - COORD_W'(1) : head.y;
  assign coord_z_o   = show_mean ? head.z - COORD_W'(1) : head.z;
  assign run_last_o  = !(show_mean && head.has_pass);
  assign ofire       = out_valid_o && !out_stall_i;
  assign opop        = ofire && run_last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q   <= '0;
      ord_q   <= '0;
      ocnt_q  <= '0;
      phase_q <= 1'b0;
    end else begin
      if (opush) begin
        owr_q <= owr_q + OUT_AW'(1);
      end
      if (opop) begin
        ord_q <= ord_q + OUT_AW'(1);
      end
      if (ofire) begin
        phase_q <= !run_last_o;
      end
      ocnt_q <= ocnt_q + OUT_CW'(opush) - OUT_CW'(opop);
    end
  end

endmodule

// File: rtl/volume_box_average_2x2x2.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_stall_o   sample_i
// out       output     out_valid_o/out_stall_i result_o, coord_x_o/y/z, run_last_o
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One voxel is accepted per cycle while the item queue has room; a voxel with two
// results sends a mean beat and then a pass-through beat, so the output port at one
// beat per cycle, when out_stall_i is low, sets the sustained rate. At the earliest,
// a result is valid once its voxel has passed queue, buffer read, partial sums, result buffer.
// Reset clears control state only; the row and plane buffers are not cleared.
// Either side may stall on its own; the item queue and the eight-entry result
// buffer absorb the difference, and issue waits for room in the result buffer.
module volume_box_average_2x2x2 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [vba_pkg::VAL_W-1:0]     sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [vba_pkg::VAL_W-1:0]     result_o,
  output logic [vba_pkg::COORD_W-1:0]   coord_x_o,
  output logic [vba_pkg::COORD_W-1:0]   coord_y_o,
  output logic [vba_pkg::COORD_W-1:0]   coord_z_o,
  output logic                          run_last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [vba_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [vba_pkg::SIZE_W-1:0]    cfg_data_i
);
  import vba_pkg::*;

  q_stat_t q_stat;
  item_t   push_item, head_item;
  logic    q_push, q_pop;

  // Front end: position tracking and classification.
  vba_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_stat_i    (q_stat),
    .q_push_o    (q_push),
    .q_item_o    (push_item)
  );

  // Item queue between the two ends.
  vba_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (push_item),
    .pop_i  (q_pop),
    .item_o (head_item),
    .stat_o (q_stat)
  );

  // Back end: buffers, cube sum and result delivery.
  vba_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .q_item_i    (head_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_o),
    .coord_x_o   (coord_x_o),
    .coord_y_o   (coord_y_o),
    .coord_z_o   (coord_z_o),
    .run_last_o  (run_last_o)
  );

endmodule

// File: rtl/vba_checker.sv
module vba_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [vba_pkg::VAL_W-1:0]     result_o,
  input logic [vba_pkg::COORD_W-1:0]   coord_x_o,
  input logic [vba_pkg::COORD_W-1:0]   coord_y_o,
  input logic [vba_pkg::COORD_W-1:0]   coord_z_o,
  input logic                          run_last_o
);
  import vba_pkg::*;

  logic out_fire;
  assign out_fire = out_valid_o && !out_stall_i;

  // A stalled result beat keeps its value and coordinates.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_o) &&
    $stable(coord_x_o) && $stable(coord_y_o) && $stable(coord_z_o) &&
    $stable(run_last_o))
    else $error("stalled result beat changed");

  // A mean that is not the last result is followed at once by its pass-through.
  a_pair_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !run_last_o |=> out_valid_o)
    else $error("second result of a voxel not ready");

  // The pass-through voxel sits one step up on every axis from its cube anchor.
  a_pair_coord: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !run_last_o |=>
    coord_x_o == $past(coord_x_o) + COORD_W'(1) &&
    coord_y_o == $past(coord_y_o) + COORD_W'(1) &&
    coord_z_o == $past(coord_z_o) + COORD_W'(1) && run_last_o)
    else $error("pass-through coordinates do not follow the mean");

  // A cube anchor never lies at the top coordinate of an axis.
  a_anchor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_last_o |->
    coord_x_o != COORD_W'(MAX_X - 1) && coord_y_o != COORD_W'(MAX_Y - 1) &&
    coord_z_o != COORD_W'(MAX_Z - 1))
    else $error("mean result at a last-face coordinate");

endmodule

bind volume_box_average_2x2x2 vba_checker u_vba_checker (.*);

// File: test/volume_box_average_2x2x2_tb.sv
module volume_box_average_2x2x2_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vba_pkg::*;

  localparam int DRAIN_CYCLES  = 32;
  localparam int RANDOM_VOXELS = 80;
  // Index that maps to no register; a write there must leave the scan alone.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(3);

  typedef struct packed {
    logic [VAL_W-1:0]   value;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               last;
  } voxel_out_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_LONG} stall_mode_e;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [VAL_W-1:0]     sample_i    = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [VAL_W-1:0]     result_o;
  logic [COORD_W-1:0]   coord_x_o;
  logic [COORD_W-1:0]   coord_y_o;
  logic [COORD_W-1:0]   coord_z_o;
  logic                 run_last_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [SIZE_W-1:0]    cfg_data_i  = '0;

  // Mirror of the filter: buffers, neighbor samples, scan position and sizes.
  logic [VAL_W-1:0]  plane_mem [PLANE_DEPTH];
  logic [VAL_W-1:0]  row_mem [MAX_X];
  logic [VAL_W-1:0]  left_s, left_row_s, left_plane_s, left_up_s;
  int unsigned       scan_x, scan_y, scan_z;
  logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;

  voxel_out_t  expected_voxels[$];
  voxel_out_t  oldest_voxel;
  int          failures       = 0;
  int          voxels_sent    = 0;
  int          results_seen   = 0;
  int          settings_used  = 0;
  int          burst_left     = 0;
  int          stall_left     = 0;
  stall_mode_e stall_mode     = STALL_NONE;

  volume_box_average_2x2x2 i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_o),
    .coord_x_o   (coord_x_o),
    .coord_y_o   (coord_y_o),
    .coord_z_o   (coord_z_o),
    .run_last_o  (run_last_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Size as the filter uses it: zero acts as one, large values clamp.
  function automatic int unsigned active_size(input logic [SIZE_W-1:0] v,
                                              input int unsigned maxv);
    if (v == '0) begin
      return 1;
    end else if (v > maxv) begin
      return maxv;
    end
    return 32'(v);
  endfunction

  // Mostly legal samples, with the ends of the range and some above 1.0.
  function automatic logic [VAL_W-1:0] random_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return VAL_W'(256);
      2: return VAL_W'($urandom_range(257, 511));
      default: return VAL_W'($urandom_range(0, 256));
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] next_size();
    if ($urandom_range(0, 7) == 0) begin
      return '0;
    end
    return SIZE_W'($urandom_range(1, 6));
  endfunction

  // Append one expected result behind the ones already waiting.
  function automatic void add_expected(input voxel_out_t r);
    expected_voxels.insert(expected_voxels.size(), r);
  endfunction

  // Advance the mirror by one voxel and queue the results it produces.
  task automatic predict_voxel(input logic [VAL_W-1:0] s);
    int unsigned sx, sy, sz, x, y, z, sum;
    logic [VAL_W-1:0] r_row, pl_here, pl_up;
    logic has_mean, has_pass;
    voxel_out_t r;
    sx = active_size(size_x_q, MAX_X);
    sy = active_size(size_y_q, MAX_Y);
    sz = active_size(size_z_q, MAX_Z);
    x = scan_x;
    y = scan_y;
    z = scan_z;
    if (x >= sx || y >= sy || z >= sz) begin
      x = 0;
      y = 0;
      z = 0;
    end

    // The row above is written back into the plane buffer one row late.
    r_row   = row_mem[x];
    pl_here = plane_mem[y * MAX_X + x];
    pl_up   = '0;
    if (y >= 1) begin
      pl_up = plane_mem[(y - 1) * MAX_X + x];
      plane_mem[(y - 1) * MAX_X + x] = r_row;
    end else begin
      plane_mem[(sy - 1) * MAX_X + x] = r_row;
    end

    has_mean = (x >= 1) && (y >= 1) && (z >= 1);
    has_pass = (x == sx - 1) || (y == sy - 1) || (z == sz - 1);
    if (has_mean) begin
      sum = 32'(s) + 32'(left_s) + 32'(r_row) + 32'(left_row_s) + 32'(pl_here)
          + 32'(left_plane_s) + 32'(pl_up) + 32'(left_up_s);
      r.value = VAL_W'(sum >> 3);
      r.x     = COORD_W'(x - 1);
      r.y     = COORD_W'(y - 1);
      r.z     = COORD_W'(z - 1);
      r.last  = !has_pass;
      add_expected(r);
    end
    if (has_pass) begin
      r.value = s;
      r.x     = COORD_W'(x);
      r.y     = COORD_W'(y);
      r.z     = COORD_W'(z);
      r.last  = 1'b1;
      add_expected(r);
    end

    left_s       = s;
    left_row_s   = r_row;
    left_plane_s = pl_here;
    left_up_s    = pl_up;
    row_mem[x]   = s;

    // Raster order, wrapping to the origin after the last voxel.
    x++;
    if (x >= sx) begin
      x = 0;
      y++;
      if (y >= sy) begin
        y = 0;
        z++;
        if (z >= sz) begin
          z = 0;
        end
      end
    end
    scan_x = x;
    scan_y = y;
    scan_z = z;
  endtask

  // Send one voxel beat; the sender runs in bursts, mostly with idle gaps between them.
  task automatic send_voxel(input logic [VAL_W-1:0] s);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (in_stall_o);
    predict_voxel(s);
    voxels_sent++;
  endtask

  // Stop sending, wait for every queued result, then let the pipeline drain.
  task automatic settle_block(input int unsigned extra_cycles);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_voxels.size() != 0) @(posedge clk_i);
    repeat (extra_cycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    // A write to any size register restarts the scan; the buffers keep their data.
    case (idx)
      REG_SIZE_X: size_x_q = val;
      REG_SIZE_Y: size_y_q = val;
      REG_SIZE_Z: size_z_q = val;
      default: ;
    endcase
    if (idx != REG_NONE) begin
      scan_x = 0;
      scan_y = 0;
      scan_z = 0;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_sizes(input logic [SIZE_W-1:0] sx, input logic [SIZE_W-1:0] sy,
                           input logic [SIZE_W-1:0] sz);
    settle_block(DRAIN_CYCLES);
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
    settings_used++;
  endtask

  // Reset sizes are 128 on every axis, so the first voxels produce nothing.
  task automatic test_default_sizes();
    logic [VAL_W-1:0] vals [6] = '{9'd0, 9'd256, 9'd511, 9'd1, 9'h155, 9'h0AA};
    foreach (vals[i]) begin
      send_voxel(vals[i]);
    end
  endtask

  // One 2x2x2 volume of full-scale samples, then a second one of zeros after
  // the wrap. The last voxel of each volume yields a mean and a pass-through.
  task automatic test_single_cube();
    set_sizes(SIZE_W'(2), SIZE_W'(2), SIZE_W'(2));
    repeat (3) send_voxel(VAL_W'(511));
    // An unused register index must not restart the scan.
    settle_block(DRAIN_CYCLES);
    write_reg(REG_NONE, SIZE_W'(1));
    repeat (5) send_voxel(VAL_W'(511));
    // Hold the sender until every result is out.
    settle_block(0);
    repeat (8) send_voxel('0);
  endtask

  // Zero and oversized registers, and each axis at its maximum length.
  task automatic test_extreme_sizes();
    logic [SIZE_W-1:0] sx_list [4] = '{8'd0, 8'd255, 8'd1, 8'd1};
    logic [SIZE_W-1:0] sy_list [4] = '{8'd0, 8'd2, 8'd128, 8'd1};
    logic [SIZE_W-1:0] sz_list [4] = '{8'd0, 8'd2, 8'd1, 8'd128};
    int unsigned counts [4] = '{12, 260, 128, 128};
    foreach (counts[i]) begin
      set_sizes(sx_list[i], sy_list[i], sz_list[i]);
      repeat (counts[i]) send_voxel(random_sample());
    end
  endtask

  // Small random volumes, one to three scans each and usually cut off mid-scan.
  task automatic test_random_volumes();
    int unsigned sent, vol, n, pause_at;
    logic [SIZE_W-1:0] sx, sy, sz;
    sent = 0;
    while (sent < RANDOM_VOXELS) begin
      sx = next_size();
      sy = next_size();
      sz = next_size();
      set_sizes(sx, sy, sz);
      vol = active_size(sx, MAX_X) * active_size(sy, MAX_Y) * active_size(sz, MAX_Z);
      n = vol * $urandom_range(1, 3) + $urandom_range(0, vol - 1);
      pause_at = (sent == 0 || $urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : n;
      for (int i = 0; i < n; i++) begin
        if (i == pause_at) begin
          settle_block(0);
        end
        send_voxel(random_sample());
      end
      sent += n;
    end
  endtask

  // Output stall pattern, changing between free running, random and long stalls.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(8, 60);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_HALF:  out_stall_i <= ($urandom_range(0, 1) == 1);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 4) != 0);
      default:     out_stall_i <= ((stall_left % 12) < 9);
    endcase
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // Each result beat is compared against the oldest expected result.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_voxels.size() == 0) begin
        $error("result beat with none expected: value %0d at (%0d,%0d,%0d)",
               result_o, coord_x_o, coord_y_o, coord_z_o);
        failures++;
      end else begin
        oldest_voxel = expected_voxels.pop_front();
        check_field("result", 32'(oldest_voxel.value), 32'(result_o));
        check_field("coord_x", 32'(oldest_voxel.x), 32'(coord_x_o));
        check_field("coord_y", 32'(oldest_voxel.y), 32'(coord_y_o));
        check_field("coord_z", 32'(oldest_voxel.z), 32'(coord_z_o));
        check_field("run_last", 32'(oldest_voxel.last), 32'(run_last_o));
        results_seen++;
      end
    end
  end

  initial begin
    for (int i = 0; i < PLANE_DEPTH; i++) begin
      plane_mem[i] = '0;
    end
    for (int i = 0; i < MAX_X; i++) begin
      row_mem[i] = '0;
    end
    left_s       = '0;
    left_row_s   = '0;
    left_plane_s = '0;
    left_up_s    = '0;
    scan_x       = 0;
    scan_y       = 0;
    scan_z       = 0;
    size_x_q     = SIZE_RESET;
    size_y_q     = SIZE_RESET;
    size_z_q     = SIZE_RESET;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_sizes();
    test_single_cube();
    test_extreme_sizes();
    test_random_volumes();
    settle_block(DRAIN_CYCLES);

    $display("Sent %0d voxels over %0d size settings and checked %0d results,",
             voxels_sent, settings_used, results_seen);
    $display("including clamped sizes, full-scale cubes, wraps and mid-scan restarts.");
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard limit for a hung handshake or missing results.
  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
